/* design/hss_pkg.sv */
// shared types and constants for the horspool substring search core
package hss_pkg;

  // alphabet covered by the bad-character shift table
  localparam int unsigned AlphaSize = 256;
  localparam int unsigned AlphaW    = 8;
  // width of the reported match position field
  localparam int unsigned PosW      = 12;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_PAT    = 2'd1,
    OP_TEXT   = 2'd2,
    OP_SEARCH = 2'd3
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_BRD,
    ST_BWR,
    ST_CRD,
    ST_CCHK,
    ST_SRD,
    ST_SLOOK,
    ST_SADV
  } srch_state_e;

  typedef struct packed {
    opcode_e           opcode;
    logic [AlphaW-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] match_position;
    logic            overflow;
  } out_item_t;

endpackage

/* design/horspool_substring_search_core.sv */
// top level of the horspool substring search core: buffers, shift table and search sequencer
//
// Pattern and text bytes are loaded one item per cycle (start high while busy is low) into
// on-chip stores of PATTERN_MAX and TEXT_MAX bytes; bytes beyond capacity are dropped and
// remembered in a sticky overflow flag that a clear item resets. A clear keeps the store
// contents but rewinds both fill counts. Only a search item gives a result: it is shown on
// result_o for exactly one cycle with done_o high and cannot be held off, so the receiver
// must take it then. A search with an empty pattern answers in the next cycle. Otherwise the
// block is busy sweeping the shift table to the pattern length, then entering the byte
// distances for every pattern byte but the last, then for every alignment comparing bytes
// and looking up and applying the shift; the result is registered from the last step.
// All of it runs through single read ports on the text, pattern and table memories with
// registered read data. Loaded pattern and text stay in place after a search, so a search
// may be repeated.
module horspool_substring_search_core #(
  parameter int unsigned PATTERN_MAX = 64,
  parameter int unsigned TEXT_MAX    = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  hss_pkg::in_item_t item_i,
  output logic              done_o,
  output hss_pkg::out_item_t result_o
);
  import hss_pkg::*;

  // count widths hold the capacity itself, address widths index the stores
  localparam int unsigned PCW = $clog2(PATTERN_MAX + 1);
  localparam int unsigned PAW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int unsigned TCW = $clog2(TEXT_MAX + 1);
  localparam int unsigned TAW = $clog2(TEXT_MAX);
  // common width for window arithmetic, one bit of headroom
  localparam int unsigned SW  = ((TCW > PCW) ? TCW : PCW) + 1;

  // storage
  logic [AlphaW-1:0] pat_mem [PATTERN_MAX];
  logic [AlphaW-1:0] txt_mem [TEXT_MAX];
  logic [PCW-1:0]    tbl_mem [AlphaSize];

  // control and datapath registers
  srch_state_e    state_q, state_d;
  logic [PCW-1:0] pat_cnt_q, pat_cnt_d;
  logic [TCW-1:0] txt_cnt_q, txt_cnt_d;
  logic           ovf_q, ovf_d;
  logic [7:0]     idx_q, idx_d;      // table sweep index, then pattern index while building
  logic [PCW-1:0] i_q, i_d;          // compare position, counts down from pattern length
  logic [TCW-1:0] s_q, s_d;          // current alignment of the pattern over the text
  logic           done_q, done_d;
  out_item_t      res_q, res_d;

  // memory ports
  logic [AlphaW-1:0] pat_rd_q, txt_rd_q;
  logic [PCW-1:0]    tbl_rd_q;
  logic [PAW-1:0]    pat_raddr;
  logic [TAW-1:0]    txt_raddr;
  logic [AlphaW-1:0] tbl_raddr;
  logic              pat_we, txt_we, tbl_we;
  logic [AlphaW-1:0] tbl_waddr;
  logic [PCW-1:0]    tbl_wdata;

  // shared conditions
  logic           accept;
  logic           is_search;
  logic           fill_last;
  logic [8:0]     m9;
  logic [8:0]     k9;
  logic           bld_first, bld_more;
  logic [SW-1:0]  s_ext, m_ext, n_ext, i_ext;
  logic [SW-1:0]  s_next;
  logic           fits_now, fits_next;
  logic           bytes_eq;
  logic [PCW-1:0] i_dec;
  logic [SW-1:0]  cmp_addr, last_addr;
  logic [8:0]     dist9;
  logic [TCW+PosW-1:0] pos_ext;

  assign busy      = (state_q != ST_IDLE);
  assign accept    = start && !busy;
  assign is_search = (item_i.opcode == OP_SEARCH);
  assign fill_last = (idx_q == 8'hFF);

  // pattern length is at most 256, so 9 bits carry the build arithmetic
  assign m9        = 9'(pat_cnt_q);
  assign k9        = {1'b0, idx_q};
  assign bld_first = (m9 > 9'd1);
  assign bld_more  = ((k9 + 9'd2) < m9);
  assign dist9     = m9 - k9 - 9'd1;

  assign s_ext     = SW'(s_q);
  assign m_ext     = SW'(pat_cnt_q);
  assign n_ext     = SW'(txt_cnt_q);
  assign i_ext     = SW'(i_q);
  assign s_next    = s_ext + SW'(tbl_rd_q);
  // window still inside the loaded text
  assign fits_now  = ((s_ext + m_ext) <= n_ext);
  assign fits_next = ((s_next + m_ext) <= n_ext);
  assign bytes_eq  = (txt_rd_q == pat_rd_q);
  assign i_dec     = i_q - PCW'(1);
  assign cmp_addr  = s_ext + i_ext - SW'(1);
  assign last_addr = s_ext + m_ext - SW'(1);
  // position field keeps the low bits only
  assign pos_ext   = {{PosW{1'b0}}, s_q};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_search && (pat_cnt_q != '0)) begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (fill_last) begin
          if (bld_first) begin
            state_d = ST_BRD;
          end else if (fits_now) begin
            state_d = ST_CRD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_BRD: state_d = ST_BWR;
      ST_BWR: begin
        if (bld_more) begin
          state_d = ST_BRD;
        end else if (fits_now) begin
          state_d = ST_CRD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_CRD: state_d = ST_CCHK;
      ST_CCHK: begin
        if (!bytes_eq) begin
          state_d = ST_SRD;
        end else if (i_q == PCW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_CRD;
        end
      end
      ST_SRD:   state_d = ST_SLOOK;
      ST_SLOOK: state_d = ST_SADV;
      ST_SADV: begin
        if (fits_next) begin
          state_d = ST_CRD;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath, memory controls and result
  always_comb begin
    pat_cnt_d = pat_cnt_q;
    txt_cnt_d = txt_cnt_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    i_d       = i_q;
    s_d       = s_q;
    done_d    = 1'b0;
    res_d     = res_q;
    pat_we    = 1'b0;
    txt_we    = 1'b0;
    tbl_we    = 1'b0;
    tbl_waddr = idx_q;
    tbl_wdata = pat_cnt_q;
    pat_raddr = idx_q[PAW-1:0];
    txt_raddr = cmp_addr[TAW-1:0];
    tbl_raddr = txt_rd_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (item_i.opcode)
            OP_CLEAR: begin
              pat_cnt_d = '0;
              txt_cnt_d = '0;
              ovf_d     = 1'b0;
            end
            OP_PAT: begin
              if (pat_cnt_q < PCW'(PATTERN_MAX)) begin
                pat_we    = 1'b1;
                pat_cnt_d = pat_cnt_q + PCW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_TEXT: begin
              if (txt_cnt_q < TCW'(TEXT_MAX)) begin
                txt_we    = 1'b1;
                txt_cnt_d = txt_cnt_q + TCW'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            OP_SEARCH: begin
              idx_d = '0;
              s_d   = '0;
              i_d   = pat_cnt_q;
              // empty pattern matches at the start of the text
              if (pat_cnt_q == '0) begin
                done_d               = 1'b1;
                res_d.found          = 1'b1;
                res_d.match_position = '0;
                res_d.overflow       = ovf_q;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FILL: begin
        tbl_we = 1'b1;
        idx_d  = idx_q + 8'd1;
        if (fill_last && !bld_first && !fits_now) begin
          done_d = 1'b1;
          res_d  = '{found: 1'b0, match_position: '0, overflow: ovf_q};
        end
      end
      ST_BRD: ;
      ST_BWR: begin
        tbl_we    = 1'b1;
        tbl_waddr = pat_rd_q;
        tbl_wdata = dist9[PCW-1:0];
        idx_d     = idx_q + 8'd1;
        if (!bld_more && !fits_now) begin
          done_d = 1'b1;
          res_d  = '{found: 1'b0, match_position: '0, overflow: ovf_q};
        end
      end
      ST_CRD: begin
        pat_raddr = i_dec[PAW-1:0];
      end
      ST_CCHK: begin
        if (bytes_eq) begin
          i_d = i_dec;
          if (i_q == PCW'(1)) begin
            done_d = 1'b1;
            res_d  = '{found: 1'b1, match_position: pos_ext[PosW-1:0], overflow: ovf_q};
          end
        end
      end
      ST_SRD: begin
        txt_raddr = last_addr[TAW-1:0];
      end
      ST_SLOOK: ;
      ST_SADV: begin
        s_d = s_next[TCW-1:0];
        i_d = pat_cnt_q;
        if (!fits_next) begin
          done_d = 1'b1;
          res_d  = '{found: 1'b0, match_position: '0, overflow: ovf_q};
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pat_cnt_q <= '0;
      txt_cnt_q <= '0;
      ovf_q     <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      pat_cnt_q <= pat_cnt_d;
      txt_cnt_q <= txt_cnt_d;
      ovf_q     <= ovf_d;
      done_q    <= done_d;
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    i_q   <= i_d;
    s_q   <= s_d;
    res_q <= res_d;
  end

  // pattern store
  always_ff @(posedge clk_i) begin
    if (pat_we) begin
      pat_mem[pat_cnt_q[PAW-1:0]] <= item_i.data_byte;
    end
    pat_rd_q <= pat_mem[pat_raddr];
  end

  // text store
  always_ff @(posedge clk_i) begin
    if (txt_we) begin
      txt_mem[txt_cnt_q[TAW-1:0]] <= item_i.data_byte;
    end
    txt_rd_q <= txt_mem[txt_raddr];
  end

  // bad-character shift table
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rd_q <= tbl_mem[tbl_raddr];
  end

  assign done_o   = done_q;
  assign result_o = res_q;

  // a result is only given as the sequencer returns to idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while search still running");

  // the table sweep never starts on an empty pattern
  a_fill_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (pat_cnt_q != '0))
    else $error("table sweep with empty pattern");

  // compare position stays within the pattern
  a_cmp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CRD) |-> ((i_q != '0) && (i_q <= pat_cnt_q)))
    else $error("compare position out of range");

  // fill counts never pass the store capacities
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pat_cnt_q <= PCW'(PATTERN_MAX)) && (txt_cnt_q <= TCW'(TEXT_MAX)))
    else $error("fill count beyond capacity");

  // a search on an empty pattern answers found in the next cycle
  a_empty_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_search && (pat_cnt_q == '0)) |=> (done_q && res_q.found))
    else $error("empty pattern search did not report a match");

endmodule

/* verif/testbench.sv */
// self-checking testbench for the horspool substring search core
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import hss_pkg::*;

  localparam int unsigned PAT_CAP = 64;
  localparam int unsigned TXT_CAP = 4096;
  // empty-pattern answer plus the full table sweep, with room to spare
  localparam int unsigned TAIL_CYCLES = 400;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      done;
  out_item_t result;

  horspool_substring_search_core #(
    .PATTERN_MAX(PAT_CAP),
    .TEXT_MAX   (TXT_CAP)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .start   (start),
    .busy    (busy),
    .item_i  (item),
    .done_o  (done),
    .result_o(result)
  );

  // shadow copy of the buffers the block holds
  logic [7:0]  pat_bytes [PAT_CAP];
  logic [7:0]  txt_bytes [TXT_CAP];
  int unsigned pat_len;
  int unsigned txt_len;
  logic        dropped_seen;

  // answers owed by the block, oldest first
  out_item_t   owed_answers [$];

  int unsigned faults;
  int unsigned items_sent;
  int unsigned searches_sent;
  int unsigned answers_seen;
  int unsigned hits_seen;
  int unsigned overflow_seen;

  // when set, the sender presents items back to back
  bit          calm;
  // symbol set the random episodes draw from
  logic [7:0]  sym_base;
  int unsigned sym_span;

  typedef struct {
    opcode_e     op;
    logic [7:0]  data;
    int unsigned reps;
    bit          typed;
    out_item_t   ans;
  } plan_row_t;

  plan_row_t plan [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic note_fault(input string msg);
    faults++;
    if (faults <= 10) $display("mismatch: %s", msg);
  endtask

  // horspool search over the shadow buffers, as the block should do it
  function automatic out_item_t predict_search();
    int unsigned skip [AlphaSize];
    int unsigned m;
    int unsigned n;
    int unsigned s;
    int unsigned i;
    out_item_t   r;
    m = pat_len;
    n = txt_len;
    s = 0;
    r.found          = 1'b0;
    r.match_position = '0;
    r.overflow       = dropped_seen;
    // empty pattern matches at the very start
    if (m == 0) begin
      r.found = 1'b1;
      return r;
    end
    for (int k = 0; k < AlphaSize; k++) skip[k] = m;
    // later occurrences overwrite earlier ones; the last byte is left out
    for (int unsigned k = 0; k + 1 < m; k++) skip[pat_bytes[k]] = m - k - 1;
    while (s + m <= n) begin
      i = m;
      while (i > 0 && txt_bytes[s + i - 1] == pat_bytes[i - 1]) i--;
      if (i == 0) begin
        r.found          = 1'b1;
        r.match_position = PosW'(s);
        return r;
      end
      s += skip[txt_bytes[s + m - 1]];
    end
    return r;
  endfunction

  // apply an accepted item to the shadow buffers
  function automatic void absorb(input in_item_t it);
    case (it.opcode)
      OP_CLEAR: begin
        pat_len      = 0;
        txt_len      = 0;
        dropped_seen = 1'b0;
      end
      OP_PAT: begin
        if (pat_len < PAT_CAP) begin
          pat_bytes[pat_len] = it.data_byte;
          pat_len++;
        end else begin
          dropped_seen = 1'b1;
        end
      end
      OP_TEXT: begin
        if (txt_len < TXT_CAP) begin
          txt_bytes[txt_len] = it.data_byte;
          txt_len++;
        end else begin
          dropped_seen = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // present one item at a falling edge and hold it until the block takes it
  task automatic issue_item(input opcode_e op, input logic [7:0] d,
                            input bit typed = 1'b0, input out_item_t ans = '0);
    int unsigned gap;
    in_item_t    it;
    it.opcode    = op;
    it.data_byte = d;
    gap = calm ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    item  <= it;
    // taken at the first rising edge that sees busy low
    do @(posedge clk); while (busy);
    if (op == OP_SEARCH) begin
      owed_answers.push_back(typed ? ans : predict_search());
      searches_sent++;
    end
    absorb(it);
    items_sent++;
    @(negedge clk);
  endtask

  function automatic plan_row_t step_row(input opcode_e op, input logic [7:0] d,
                                         input int unsigned reps = 1,
                                         input bit typed = 1'b0, input logic f = 1'b0,
                                         input logic [PosW-1:0] p = '0,
                                         input logic o = 1'b0);
    plan_row_t r;
    r.op    = op;
    r.data  = d;
    r.reps  = reps;
    r.typed = typed;
    r.ans   = '{found: f, match_position: p, overflow: o};
    return r;
  endfunction

  function automatic logic [7:0] rand_sym();
    return sym_base + 8'($urandom_range(0, sym_span - 1));
  endfunction

  // one well-formed load-and-search sequence, with some noise mixed in
  task automatic run_episode();
    int unsigned plen;
    int unsigned tlen;
    int unsigned where;
    int unsigned nsrch;
    int unsigned pick;
    bit          plant;
    logic [7:0]  pat_buf [$];
    logic [7:0]  b;
    calm     = ($urandom_range(0, 3) == 0);
    sym_base = 8'($urandom);
    case ($urandom_range(0, 4))
      0:       sym_span = 1;
      1:       sym_span = 2;
      2:       sym_span = 3;
      3:       sym_span = 4;
      default: sym_span = 256;
    endcase
    // mostly start afresh; now and then build on what is loaded
    if (txt_len > 400 || pat_len >= PAT_CAP || $urandom_range(0, 7) != 0)
      issue_item(OP_CLEAR, 8'($urandom));
    pick = $urandom_range(0, 19);
    if (pick == 0)       plen = 0;
    else if (pick <= 13) plen = $urandom_range(1, 6);
    else if (pick <= 17) plen = $urandom_range(7, 20);
    else if (pick == 18) plen = $urandom_range(60, 68);
    else                 plen = $urandom_range(1, 3);
    for (int unsigned k = 0; k < plen; k++) begin
      b = rand_sym();
      pat_buf.push_back(b);
      issue_item(OP_PAT, b);
    end
    tlen  = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(0, 64);
    plant = (plen <= tlen) && ($urandom_range(0, 2) != 0);
    where = plant ? $urandom_range(0, tlen - plen) : 0;
    for (int unsigned k = 0; k < tlen; k++) begin
      if (plant && k >= where && k < where + plen) b = pat_buf[k - where];
      else b = rand_sym();
      issue_item(OP_TEXT, b);
    end
    nsrch = $urandom_range(1, 2);
    for (int unsigned k = 0; k < nsrch; k++) begin
      issue_item(OP_SEARCH, 8'($urandom));
      // noise: any item at all, then search again
      if ($urandom_range(0, 3) == 0) begin
        issue_item(opcode_e'($urandom_range(0, 3)), 8'($urandom));
        issue_item(OP_SEARCH, 8'($urandom));
      end
    end
  endtask

  // result checker: every strobe is matched against the oldest owed answer
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && done) begin
      answers_seen++;
      if (result.found === 1'b1) hits_seen++;
      if (result.overflow === 1'b1) overflow_seen++;
      if (owed_answers.size() == 0) begin
        note_fault($sformatf("result with no search outstanding: found=%0d pos=%0d ovf=%0d",
                             result.found, result.match_position, result.overflow));
      end else begin
        want = owed_answers.pop_front();
        if (result.found !== want.found || result.match_position !== want.match_position ||
            result.overflow !== want.overflow)
          note_fault($sformatf("expected found=%0d pos=%0d ovf=%0d, got found=%0d pos=%0d ovf=%0d",
                               want.found, want.match_position, want.overflow,
                               result.found, result.match_position, result.overflow));
      end
    end
  end

  initial begin
    start         = 1'b0;
    item          = '0;
    rst_n         = 1'b0;
    calm          = 1'b0;
    sym_base      = '0;
    sym_span      = 256;
    pat_len       = 0;
    txt_len       = 0;
    dropped_seen  = 1'b0;
    faults        = 0;
    items_sent    = 0;
    searches_sent = 0;
    answers_seen  = 0;
    hits_seen     = 0;
    overflow_seen = 0;

    // directed part: typed answers where they are obvious, predictor elsewhere
    // empty pattern straight after reset
    plan.push_back(step_row(OP_SEARCH, 8'h00, 1, 1'b1, 1'b1, 12'd0, 1'b0));
    plan.push_back(step_row(OP_TEXT,   8'h61));
    // empty pattern over a loaded text
    plan.push_back(step_row(OP_SEARCH, 8'hFF, 1, 1'b1, 1'b1, 12'd0, 1'b0));
    // pattern longer than the text
    plan.push_back(step_row(OP_PAT,    8'hFF, 2));
    plan.push_back(step_row(OP_SEARCH, 8'h5A, 1, 1'b1, 1'b0, 12'd0, 1'b0));
    plan.push_back(step_row(OP_CLEAR,  8'hAA));
    // the only hit sits at the last byte of the text
    plan.push_back(step_row(OP_TEXT,   8'h00, 40));
    plan.push_back(step_row(OP_TEXT,   8'hFF));
    plan.push_back(step_row(OP_PAT,    8'hFF));
    plan.push_back(step_row(OP_SEARCH, 8'h00, 1, 1'b1, 1'b1, 12'd40, 1'b0));
    // two-byte pattern walked over the same text, no hit
    plan.push_back(step_row(OP_PAT,    8'h00));
    plan.push_back(step_row(OP_SEARCH, 8'h0F));
    // full pattern store plus one dropped byte
    plan.push_back(step_row(OP_CLEAR,  8'h55));
    plan.push_back(step_row(OP_PAT,    8'h00, PAT_CAP + 1));
    plan.push_back(step_row(OP_TEXT,   8'h00, 70));
    plan.push_back(step_row(OP_SEARCH, 8'hF0, 1, 1'b1, 1'b1, 12'd0, 1'b1));
    // clear drops the overflow flag too
    plan.push_back(step_row(OP_CLEAR,  8'h00));
    plan.push_back(step_row(OP_SEARCH, 8'h81, 1, 1'b1, 1'b1, 12'd0, 1'b0));
    // mismatches with real shifts before a hit, then the same search repeated
    plan.push_back(step_row(OP_PAT,    8'h61));
    plan.push_back(step_row(OP_PAT,    8'h62));
    plan.push_back(step_row(OP_TEXT,   8'h62, 3));
    plan.push_back(step_row(OP_TEXT,   8'h61));
    plan.push_back(step_row(OP_TEXT,   8'h62));
    plan.push_back(step_row(OP_SEARCH, 8'h7E, 2));

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[r])
      repeat (plan[r].reps) issue_item(plan[r].op, plan[r].data, plan[r].typed, plan[r].ans);

    // random part: episodes until enough items have gone in
    while (items_sent < 880) run_episode();

    start <= 1'b0;
    // drain: nothing owed, then a quiet tail to catch stray strobes
    while (owed_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("ran %0d items, %0d searches; %0d answers checked, %0d hits, %0d flagged overflow",
             items_sent, searches_sent, answers_seen, hits_seen, overflow_seen);
    $display("%0d faults found", faults);
    if (faults == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* files.f */
design/hss_pkg.sv
design/horspool_substring_search_core.sv
verif/testbench.sv
